[rtl/core/fpwa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fpwa_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned WIDX_W     = 3;
  // bits of the start address that take part in page alignment
  localparam logic [ADDR_W-1:0] ADDR_LOW_MASK = 32'h00FF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BANK0_START = 2'd0,
    REG_BANK0_END   = 2'd1,
    REG_BANK1_START = 2'd2,
    REG_BANK1_END   = 2'd3
  } fpwa_reg_e;

  // control part of one queued page or rejection
  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    logic              done;
    logic              reject;
  } fpwa_ctl_t;

endpackage

`default_nettype wire

[rtl/core/fpwa_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpwa_front
  import fpwa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // configuration
  input  wire logic                      cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [31:0]               cfg_data_i,
  // byte stream
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [31:0]               start_address_i,
  input  wire logic [31:0]               total_length_i,
  input  wire logic [7:0]                data_byte_i,
  input  wire logic                      first_i,
  input  wire logic                      last_i,
  // page queue write side
  output logic                           push_o,
  output fpwa_ctl_t                      push_ctl_o,
  output logic [PAGE_BYTES*8-1:0]        push_data_o,
  input  wire logic                      full_i
);

  localparam int unsigned LG = $clog2(PAGE_BYTES);
  localparam logic [LG-1:0] POS_LAST = LG'(PAGE_BYTES - 1);
  localparam logic [ADDR_W-1:0] ALIGN_MASK = ~ADDR_W'(PAGE_BYTES - 1);

  logic [31:0] bank0_start_q, bank0_end_q, bank1_start_q, bank1_end_q;

  logic [7:0]            buf_q [PAGE_BYTES];
  logic [PAGE_BYTES-1:0] vld_q, vld_d;
  logic [LG-1:0]         fill_q, fill_d;
  logic [ADDR_W-1:0]     page_addr_q, page_addr_d;
  logic                  discard_q, discard_d;

  logic              accept;
  logic [32:0]       span_hi;
  logic              in_b0, in_b1, range_ok;
  logic              reject, wr_byte, emit;
  logic [LG-1:0]     pos;
  logic [PAGE_BYTES-1:0] base_vld;
  logic [ADDR_W-1:0] base_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank0_start_q <= '0;
      bank0_end_q   <= '0;
      bank1_start_q <= '0;
      bank1_end_q   <= '0;
    end else if (cfg_valid_i) begin
      case (fpwa_reg_e'(cfg_index_i))
        REG_BANK0_START: bank0_start_q <= cfg_data_i;
        REG_BANK0_END:   bank0_end_q   <= cfg_data_i;
        REG_BANK1_START: bank1_start_q <= cfg_data_i;
        REG_BANK1_END:   bank1_end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // span end without 32-bit wraparound
  assign span_hi  = {1'b0, start_address_i} + {1'b0, total_length_i} - 33'd1;
  assign in_b0    = (start_address_i >= bank0_start_q) && (span_hi <= {1'b0, bank0_end_q});
  assign in_b1    = (start_address_i >= bank1_start_q) && (span_hi <= {1'b0, bank1_end_q});
  assign range_ok = (total_length_i != 32'd0) && (in_b0 || in_b1);

  assign reject  = accept && first_i && !range_ok;
  assign wr_byte = accept && (first_i ? range_ok : !discard_q);

  always_comb begin
    if (first_i) begin
      pos       = LG'(start_address_i & ADDR_LOW_MASK);
      base_vld  = '0;
      base_addr = start_address_i & ALIGN_MASK;
    end else begin
      pos       = fill_q;
      base_vld  = vld_q;
      base_addr = page_addr_q;
    end
  end

  assign emit = wr_byte && ((pos == POS_LAST) || last_i);

  // page image with the incoming byte merged, unwritten bytes zero
  always_comb begin
    for (int i = 0; i < PAGE_BYTES; i++) begin
      if (pos == LG'(i)) begin
        push_data_o[i*8 +: 8] = data_byte_i;
      end else if (base_vld[i]) begin
        push_data_o[i*8 +: 8] = buf_q[i];
      end else begin
        push_data_o[i*8 +: 8] = 8'h00;
      end
    end
  end

  assign push_o = reject || emit;

  always_comb begin
    push_ctl_o.page_addr = reject ? '0 : base_addr;
    push_ctl_o.done      = reject || last_i;
    push_ctl_o.reject    = reject;
  end

  always_comb begin
    vld_d       = vld_q;
    fill_d      = fill_q;
    page_addr_d = page_addr_q;
    discard_d   = discard_q;
    if (reject) begin
      vld_d     = '0;
      fill_d    = '0;
      discard_d = 1'b1;
    end else if (emit) begin
      vld_d       = '0;
      fill_d      = '0;
      page_addr_d = base_addr + ADDR_W'(PAGE_BYTES);
      discard_d   = last_i;
    end else if (wr_byte) begin
      vld_d       = base_vld;
      vld_d[pos]  = 1'b1;
      fill_d      = pos + LG'(1);
      page_addr_d = base_addr;
      discard_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      fill_q      <= '0;
      page_addr_q <= '0;
      discard_q   <= 1'b0;
    end else begin
      vld_q       <= vld_d;
      fill_q      <= fill_d;
      page_addr_q <= page_addr_d;
      discard_q   <= discard_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_byte && !emit) begin
      buf_q[pos] <= data_byte_i;
    end
  end

  a_reject_on_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && push_ctl_o.reject |-> first_i && accept)
    else $error("rejection without a first byte");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("page pushed into a full queue");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (vld_q == '0) && (fill_q == '0))
    else $error("page buffer not cleared after hand-off");

endmodule

`default_nettype wire

[rtl/core/fpwa_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpwa_queue
  import fpwa_pkg::*;
#(
  parameter int unsigned DATA_W = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire fpwa_ctl_t         push_ctl_i,
  input  wire logic [DATA_W-1:0] push_data_i,
  output logic                   full_o,
  output logic                   head_valid_o,
  output fpwa_ctl_t              head_ctl_o,
  output logic [DATA_W-1:0]      head_data_o,
  input  wire logic              pop_i
);

  // two pages: one draining, one being handed over
  fpwa_ctl_t         ctl_q  [2];
  logic [DATA_W-1:0] data_q [2];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q, cnt_d;

  assign full_o       = cnt_q[1];
  assign head_valid_o = cnt_q != 2'd0;
  assign head_ctl_o   = ctl_q[rd_q];
  assign head_data_o  = data_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_q[wr_q]  <= push_ctl_i;
      data_q[wr_q] <= push_data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[rtl/core/fpwa_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module fpwa_back
  import fpwa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   head_valid_i,
  input  wire fpwa_ctl_t              head_ctl_i,
  input  wire logic [PAGE_BYTES*8-1:0] head_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [31:0]                 page_address_o,
  output logic [WIDX_W-1:0]           word_index_o,
  output logic [31:0]                 page_word_o,
  output logic                        word_last_o,
  output logic                        request_done_o,
  output logic                        status_o
);

  localparam int unsigned WORDS = PAGE_BYTES / 4;
  localparam int unsigned WL    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam logic [WL-1:0] WC_LAST = WL'(WORDS - 1);

  logic [WL-1:0] wc_q;
  logic          load, is_last;
  logic          out_valid_q;
  logic [31:0]   addr_q, word_q;
  logic [WIDX_W-1:0] idx_q;
  logic          wlast_q, done_q, status_q;

  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = head_ctl_i.reject || (wc_q == WC_LAST);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        wc_q        <= is_last ? '0 : wc_q + WL'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (head_ctl_i.reject) begin
        addr_q   <= '0;
        idx_q    <= '0;
        word_q   <= '0;
        wlast_q  <= 1'b0;
        done_q   <= 1'b1;
        status_q <= 1'b1;
      end else begin
        addr_q   <= head_ctl_i.page_addr;
        idx_q    <= WIDX_W'(wc_q);
        word_q   <= head_data_i[{wc_q, 5'd0} +: 32];
        wlast_q  <= wc_q == WC_LAST;
        done_q   <= head_ctl_i.done && (wc_q == WC_LAST);
        status_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign page_address_o = addr_q;
  assign word_index_o   = idx_q;
  assign page_word_o    = word_q;
  assign word_last_o    = wlast_q;
  assign request_done_o = done_q;
  assign status_o       = status_q;

  a_reject_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && head_ctl_i.reject |-> wc_q == '0)
    else $error("rejection taken in the middle of a page");

  a_pop_resets_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> wc_q == '0)
    else $error("word counter not rewound after page");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q && !status_q |-> wlast_q)
    else $error("request end flagged before final word");

endmodule

`default_nettype wire

[rtl/core/flash_page_write_assembler.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// cfg       in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_stall_o   start_address_i, total_length_i,
//                                                data_byte_i, first_i, last_i
// out       out        out_valid_o / out_stall_i page_address_o, word_index_o,
//                                                page_word_o, word_last_o,
//                                                request_done_o, status_o
//
// one byte is taken per cycle while the queue is not full; a page leaves as PAGE_BYTES/4
// words, one per cycle while out_stall_i is low; the bank range check and page merge are
// combinational in the front, ahead of a two-page queue; the byte side stalls only while that queue is full
// a rejection or page passes through the queue and then the output register
// reset clears banks, fill position, page address and the discard flag
// PAGE_BYTES is a power of two

module flash_page_write_assembler
  import fpwa_pkg::*;
#(
  parameter int unsigned PAGE_BYTES = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [31:0]          start_address_i,
  input  wire logic [31:0]          total_length_i,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 first_i,
  input  wire logic                 last_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [31:0]               page_address_o,
  output logic [WIDX_W-1:0]         word_index_o,
  output logic [31:0]               page_word_o,
  output logic                      word_last_o,
  output logic                      request_done_o,
  output logic                      status_o
);

  localparam int unsigned DATA_W = PAGE_BYTES * 8;

  logic              push, full, head_valid, pop;
  fpwa_ctl_t         push_ctl, head_ctl;
  logic [DATA_W-1:0] push_data, head_data;

  assign cfg_ready_o = 1'b1;

  fpwa_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .start_address_i,
    .total_length_i,
    .data_byte_i,
    .first_i,
    .last_i,
    .push_o      (push),
    .push_ctl_o  (push_ctl),
    .push_data_o (push_data),
    .full_i      (full)
  );

  fpwa_queue #(.DATA_W(DATA_W)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_ctl_i   (push_ctl),
    .push_data_i  (push_data),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_ctl_o   (head_ctl),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  fpwa_back #(.PAGE_BYTES(PAGE_BYTES)) u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_ctl_i   (head_ctl),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o,
    .out_stall_i,
    .page_address_o,
    .word_index_o,
    .page_word_o,
    .word_last_o,
    .request_done_o,
    .status_o
  );

endmodule

`default_nettype wire

[test/tb_flash_page_write_assembler.sv]
`timescale 1ns / 1ps

// one word of a programmed page, or a rejection
typedef struct packed {
  logic [31:0]                   page_address;
  logic [fpwa_pkg::WIDX_W-1:0]   word_index;
  logic [31:0]                   page_word;
  logic                          word_last;
  logic                          request_done;
  logic                          status;
} flash_word_t;

class page_scoreboard;
  localparam int unsigned PageBytes = 32;

  logic [31:0]  bank_lo [2];
  logic [31:0]  bank_hi [2];
  logic [7:0]   page_bytes [PageBytes];
  int unsigned  fill_pos;
  logic [31:0]  page_addr;
  bit           discarding;
  flash_word_t  expected_words [$];
  int           fail_count;

  function new();
    bank_lo = '{32'd0, 32'd0};
    bank_hi = '{32'd0, 32'd0};
    clear_page();
    page_addr  = '0;
    discarding = 1'b0;
    fail_count = 0;
  endfunction

  function void clear_page();
    foreach (page_bytes[i]) page_bytes[i] = 8'h00;
    fill_pos = 0;
  endfunction

  function void write_reg(fpwa_pkg::fpwa_reg_e idx, logic [31:0] value);
    case (idx)
      fpwa_pkg::REG_BANK0_START: bank_lo[0] = value;
      fpwa_pkg::REG_BANK0_END:   bank_hi[0] = value;
      fpwa_pkg::REG_BANK1_START: bank_lo[1] = value;
      fpwa_pkg::REG_BANK1_END:   bank_hi[1] = value;
      default: ;
    endcase
  endfunction

  function void emit_page(bit done);
    flash_word_t w;
    for (int i = 0; i < PageBytes / 4; i++) begin
      w.page_address = page_addr;
      w.word_index   = i[fpwa_pkg::WIDX_W-1:0];
      w.page_word    = {page_bytes[4*i+3], page_bytes[4*i+2],
                        page_bytes[4*i+1], page_bytes[4*i]};
      w.word_last    = (i == PageBytes / 4 - 1);
      w.request_done = done && (i == PageBytes / 4 - 1);
      w.status       = 1'b0;
      expected_words.push_back(w);
    end
  endfunction

  // returns 0 when the byte is dropped without effect
  function bit take_byte(logic [31:0] addr, logic [31:0] len, logic [7:0] data,
                         bit first, bit last);
    logic [32:0] span_end;
    bit          fits;
    flash_word_t rej;
    if (first) begin
      // span end kept in 33 bits so it cannot wrap
      span_end = {1'b0, addr} + {1'b0, len} - 33'd1;
      fits = 1'b0;
      for (int b = 0; b < 2; b++)
        if (addr >= bank_lo[b] && span_end <= {1'b0, bank_hi[b]}) fits = 1'b1;
      clear_page();
      if (len == 32'd0 || !fits) begin
        discarding = 1'b1;
        rej = '0;
        rej.request_done = 1'b1;
        rej.status = 1'b1;
        expected_words.push_back(rej);
        return 1'b1;
      end
      discarding = 1'b0;
      fill_pos  = (addr & fpwa_pkg::ADDR_LOW_MASK) % PageBytes;
      page_addr = addr - fill_pos;
    end else if (discarding) begin
      return 1'b0;
    end
    page_bytes[fill_pos % PageBytes] = data;
    fill_pos++;
    if (fill_pos >= PageBytes || last) begin
      emit_page(last);
      clear_page();
      page_addr += PageBytes;
      if (last) discarding = 1'b1;
    end
    return 1'b1;
  endfunction

  task report_mismatch(string what);
    $display("ERROR: %s", what);
    fail_count++;
  endtask

  task check_word(flash_word_t got);
    flash_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("word with nothing pending: %h", got));
      return;
    end
    want = expected_words.pop_front();
    if (got.page_address !== want.page_address)
      report_mismatch($sformatf("page_address %h, want %h", got.page_address,
                                want.page_address));
    if (got.word_index !== want.word_index)
      report_mismatch($sformatf("word_index %0d, want %0d", got.word_index,
                                want.word_index));
    if (got.page_word !== want.page_word)
      report_mismatch($sformatf("page_word %h, want %h at page %h word %0d",
                                got.page_word, want.page_word, want.page_address,
                                want.word_index));
    if (got.word_last !== want.word_last)
      report_mismatch($sformatf("word_last %b, want %b", got.word_last, want.word_last));
    if (got.request_done !== want.request_done)
      report_mismatch($sformatf("request_done %b, want %b", got.request_done,
                                want.request_done));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %b, want %b", got.status, want.status));
  endtask
endclass

module tb_flash_page_write_assembler;
  import fpwa_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 12;

  typedef enum {REQ_CLEAN, REQ_TRUNCATED, REQ_NOISE, REQ_STRAY} request_kind_e;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_valid_i     = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i     = '0;
  logic [31:0]          cfg_data_i      = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [31:0]          start_address_i = '0;
  logic [31:0]          total_length_i  = '0;
  logic [7:0]           data_byte_i     = '0;
  logic                 first_i         = 1'b0;
  logic                 last_i          = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [31:0]          page_address_o;
  logic [WIDX_W-1:0]    word_index_o;
  logic [31:0]          page_word_o;
  logic                 word_last_o;
  logic                 request_done_o;
  logic                 status_o;

  page_scoreboard sb = new();
  int             items_used = 0;
  bit             send_idle  = 1'b1;
  int             quiet_cycles = 0;

  flash_page_write_assembler u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .start_address_i (start_address_i),
    .total_length_i  (total_length_i),
    .data_byte_i     (data_byte_i),
    .first_i         (first_i),
    .last_i          (last_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .page_address_o  (page_address_o),
    .word_index_o    (word_index_o),
    .page_word_o     (page_word_o),
    .word_last_o     (word_last_o),
    .request_done_o  (request_done_o),
    .status_o        (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_byte(logic [31:0] addr, logic [31:0] len, logic [7:0] data,
                           bit first, bit last);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    start_address_i <= addr;
    total_length_i  <= len;
    data_byte_i     <= data;
    first_i         <= first;
    last_i          <= last;
    do @(posedge clk_i); while (in_stall_o);
    void'(sb.take_byte(addr, len, data, first, last));
    items_used++;
  endtask

  // stop sending, let every pending word out, then cover in-flight bytes
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_banks(logic [31:0] lo0, logic [31:0] hi0,
                           logic [31:0] lo1, logic [31:0] hi1);
    logic [31:0] vals [4];
    fpwa_reg_e   idx;
    vals = '{lo0, hi0, lo1, hi1};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      idx = fpwa_reg_e'(i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx, vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_request(request_kind_e kind);
    longint unsigned lo, hi, room;
    logic [31:0]     addr, len;
    int unsigned     nbytes;
    int              b;
    b  = $urandom_range(0, 1);
    lo = sb.bank_lo[b];
    hi = sb.bank_hi[b];
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(65, 260) : $urandom_range(1, 64);
    nbytes = len;
    if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(1, len + 40);
    if (kind == REQ_NOISE) begin
      addr   = $urandom;
      len    = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
      nbytes = $urandom_range(1, 6);
    end else if (hi >= lo && hi - lo + 1 >= len) begin
      room = hi - lo + 2 - len;
      addr = lo + ({$urandom, $urandom} % room);
    end else begin
      addr = $urandom;
    end
    if (kind == REQ_TRUNCATED) nbytes = $urandom_range(1, nbytes);
    if (kind == REQ_STRAY) nbytes = $urandom_range(1, 4);
    send_idle = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < nbytes; i++) begin
      if (kind == REQ_STRAY)
        send_byte($urandom, $urandom, $urandom_range(0, 255), 1'b0, $urandom_range(0, 1));
      else
        send_byte(i == 0 ? addr : $urandom, i == 0 ? len : $urandom,
                  $urandom_range(0, 255), i == 0,
                  i == nbytes - 1 && kind != REQ_TRUNCATED);
    end
  endtask

  task automatic random_requests(int target);
    int            start;
    int            pick;
    request_kind_e kind;
    start = items_used;
    while (items_used - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      kind = REQ_CLEAN;
      else if (pick < 80) kind = REQ_TRUNCATED;
      else if (pick < 90) kind = REQ_NOISE;
      else                kind = REQ_STRAY;
      send_request(kind);
    end
  endtask

  function automatic logic [31:0] bank_top(logic [31:0] lo);
    longint unsigned hi;
    if ($urandom_range(0, 3) == 0) return $urandom;
    hi = longint'(lo) + $urandom_range(0, 4095);
    return (hi > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : hi[31:0];
  endfunction

  // result side: random stall per word, with stretches of none
  initial begin : result_side
    int          stall_left;
    bit          burst;
    flash_word_t got;
    stall_left = 0;
    burst = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.page_address = page_address_o;
        got.word_index   = word_index_o;
        got.page_word    = page_word_o;
        got.word_last    = word_last_o;
        got.request_done = request_done_o;
        got.status       = status_o;
        sb.check_word(got);
        if ($urandom_range(0, 31) == 0) burst = !burst;
        stall_left = burst ? 0 : $urandom_range(0, 9);
        out_stall_i <= (stall_left != 0);
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] lo;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // banks at reset value: only address 0 with length 1 fits
    send_byte(32'd0, 32'd0, 8'hA5, 1'b0, 1'b0);  // bytes before any request land at page 0
    send_byte(32'd0, 32'd0, 8'h00, 1'b0, 1'b1);
    send_byte(32'd0, 32'd0, 8'h77, 1'b0, 1'b1);  // stray after end is dropped
    send_byte(32'd0, 32'd0, 8'h01, 1'b1, 1'b1);  // zero length
    send_byte(32'd0, 32'd1, 8'hFF, 1'b1, 1'b1);
    send_byte(32'd1, 32'd1, 8'h02, 1'b1, 1'b1);

    set_banks(32'h0000_1000, 32'h0000_1FFF, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_byte(32'h0000_1FFF, 32'd1, 8'hC3, 1'b1, 1'b1);  // last byte of bank fills page
    send_byte(32'h0000_1FFF, 32'd2, 8'h03, 1'b1, 1'b1);  // one past bank end
    send_byte(32'h0000_0FFF, 32'd1, 8'h04, 1'b1, 1'b1);  // one below bank start
    send_byte(32'hFFFF_FFFF, 32'd1, 8'h96, 1'b1, 1'b0);  // page address wraps to 0
    send_byte(32'h0, 32'h0, 8'h5A, 1'b0, 1'b1);
    send_byte(32'hFFFF_FF00, 32'hFFFF_FFFF, 8'h05, 1'b1, 1'b1);  // span beyond 32 bits
    send_byte(32'hFFFF_FF00, 32'h100, 8'h11, 1'b1, 1'b0);
    send_byte(32'h0, 32'h0, 8'h22, 1'b0, 1'b0);
    send_byte(32'h0000_1010, 32'h10, 8'h33, 1'b1, 1'b0);  // new request drops partial page
    send_byte(32'h0, 32'h0, 8'h44, 1'b0, 1'b1);
    send_byte(32'h0, 32'h0, 8'h55, 1'b0, 1'b0);
    send_byte(32'h0000_1000, 32'd0, 8'h06, 1'b1, 1'b0);
    send_byte(32'h0, 32'h0, 8'h66, 1'b0, 1'b1);  // last while rejected is dropped

    set_banks(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_byte(32'd0, 32'hFFFF_FFFF, 8'h80, 1'b1, 1'b1);
    send_byte(32'd1, 32'hFFFF_FFFF, 8'h81, 1'b1, 1'b1);
    send_byte(32'd2, 32'hFFFF_FFFF, 8'h82, 1'b1, 1'b1);
    send_byte(32'hFFFF_FFFF, 32'd1, 8'h83, 1'b1, 1'b1);

    random_requests(75);
    wait_idle();  // sender holds until the result side is empty
    random_requests(75);

    lo = $urandom;
    set_banks(lo, bank_top(lo), 32'hFFFF_F000, 32'hFFFF_FFFF);
    random_requests(140);

    lo = $urandom;
    set_banks(lo, bank_top(lo), 32'h0000_0400, 32'h0000_0BFF);
    random_requests(140);

    wait_idle();
    foreach (sb.expected_words[i])
      sb.report_mismatch($sformatf("word never came for page %h",
                                   sb.expected_words[i].page_address));
    if (sb.fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
